// ===== hdl/tdp_pkg.sv =====
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int VALUE_WIDTH = 32;
  // trial divisor reaches one odd step past the square root bound
  localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_HOLD
  } tdp_state_e;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [DIV_WIDTH-1:0]   divisor;
  } tdp_div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [DIV_WIDTH-1:0]   rem;
  } tdp_div_rsp_t;

endpackage

// ===== hdl/tdp_if.sv =====
`timescale 1ns / 1ps

interface tdp_cand_if;
  import tdp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_result_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== hdl/tdp_div.sv =====
`timescale 1ns / 1ps

module tdp_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdp_pkg::tdp_div_req_t req_i,
  output tdp_pkg::tdp_div_rsp_t rsp_o
);
  import tdp_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [DIV_WIDTH-1:0]   rem_q, rem_d;
  logic [DIV_WIDTH-1:0]   dvs_q, dvs_d;

  logic [DIV_WIDTH:0] rem_shift;
  logic [DIV_WIDTH:0] rem_sub;
  logic               ge;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign rem_shift = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};
  assign ge        = rem_shift >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_WIDTH'(VALUE_WIDTH - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
      rem_d = ge ? rem_sub[DIV_WIDTH-1:0] : rem_shift[DIV_WIDTH-1:0];
      cnt_d = cnt_q - CNT_WIDTH'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/tdp_seq.sv =====
`timescale 1ns / 1ps

module tdp_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cand_valid_i,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0] cand_i,
  output logic                         cand_ready_o,
  output tdp_pkg::tdp_div_req_t        div_req_o,
  input  tdp_pkg::tdp_div_rsp_t        div_rsp_i,
  output logic                         res_valid_o,
  output logic                         res_prime_o,
  input  logic                         res_ready_i
);
  import tdp_pkg::*;

  tdp_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] held_q, held_d;
  logic [DIV_WIDTH-1:0]   trial_q, trial_d;
  logic                   prime_q, prime_d;

  logic cand_xfer;
  logic small_cand;
  logic first_div;
  logic exit_prime;
  logic exit_comp;

  assign cand_xfer  = cand_valid_i && (state_q == ST_IDLE);
  assign small_cand = (cand_i[VALUE_WIDTH-1:2] == '0);
  assign first_div  = (trial_q == DIV_WIDTH'(2));
  // quotient below the divisor means divisor squared exceeds the candidate
  assign exit_prime = !first_div && (div_rsp_i.quot < VALUE_WIDTH'(trial_q));
  assign exit_comp  = !exit_prime && (div_rsp_i.rem == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cand_xfer) begin
          state_d = small_cand ? ST_HOLD : ST_START;
        end
      end
      ST_START: state_d = ST_RUN;
      ST_RUN: begin
        if (div_rsp_i.done) begin
          state_d = (exit_prime || exit_comp) ? ST_HOLD : ST_START;
        end
      end
      ST_HOLD: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    held_d             = held_q;
    trial_d            = trial_q;
    prime_d            = prime_q;
    cand_ready_o       = 1'b0;
    res_valid_o        = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = held_q;
    div_req_o.divisor  = trial_q;
    case (state_q)
      ST_IDLE: begin
        cand_ready_o = 1'b1;
        if (cand_xfer) begin
          held_d  = cand_i;
          trial_d = DIV_WIDTH'(2);
          prime_d = cand_i[1];
        end
      end
      ST_START: div_req_o.start = 1'b1;
      ST_RUN: begin
        if (div_rsp_i.done) begin
          prime_d = exit_prime;
          trial_d = first_div ? DIV_WIDTH'(3) : trial_q + DIV_WIDTH'(2);
        end
      end
      ST_HOLD: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q  <= held_d;
    trial_q <= trial_d;
    prime_q <= prime_d;
  end

  assign res_prime_o = prime_q;

endmodule

// ===== hdl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                    Transfer
// cand_i    in   valid, ready, candidate    valid && ready
// result_o  out  valid, ready, is_prime     valid && ready
//
// Candidates below 4 are answered straight from the input transfer, with no division.
// Larger ones run one trial divisor at a time through the shared
// bit-serial remainder unit until one divides or the square root bound is passed.
// Reset clears control only; no item is accepted while a test runs.
// A finished result waits in the output register; a stalled result channel
// holds the sequencer only once the next result is ready.

module trial_division_prime_test (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdp_cand_if.sink   cand_i,
  tdp_result_if.source result_o
);
  import tdp_pkg::*;

  tdp_div_req_t div_req;
  tdp_div_rsp_t div_rsp;

  logic seq_valid;
  logic seq_prime;
  logic seq_ready;
  logic out_valid_q, out_valid_d;
  logic out_prime_q, out_prime_d;

  tdp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tdp_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (cand_i.valid),
    .cand_i       (cand_i.candidate),
    .cand_ready_o (cand_i.ready),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_valid_o  (seq_valid),
    .res_prime_o  (seq_prime),
    .res_ready_i  (seq_ready)
  );

  assign seq_ready = !out_valid_q || result_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;
    if (seq_ready) begin
      out_valid_d = seq_valid;
      out_prime_d = seq_prime;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_prime_q <= out_prime_d;
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.is_prime = out_prime_q;

endmodule

// ===== hdl/tdp_checker.sv =====
`timescale 1ns / 1ps

module tdp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cand_valid_i,
  input logic cand_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_prime_i
);

  // busy right after a candidate transfer
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_valid_i && cand_ready_i |=> !cand_ready_i)
    else $error("candidate accepted while a test is running");

  // a new result only appears after the sequencer was busy
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!cand_ready_i))
    else $error("result without a preceding test");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_prime_i))
    else $error("stalled result changed");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cand_valid_i (cand_i.valid),
  .cand_ready_i (cand_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_prime_i  (result_o.is_prime)
);
